[design/skm_pkg.sv]
`default_nettype none

package skm_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS = 18;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int ID_W        = 56;
	localparam int CODE_W      = 24;
	localparam int ID_BYTES    = ID_W / 8;
	localparam int CODE_BYTES  = CODE_W / 8;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [1:0] {
		ACT_LOWER_KEY = 2'd0,
		ACT_UPPER_KEY = 2'd1,
		ACT_LOWER_END = 2'd2,
		ACT_UPPER_END = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		SRC_LOWER,
		SRC_UPPER,
		SRC_MARK
	} src_t;

	typedef struct packed {
		logic take_in;
		logic emit;
		src_t src;
		logic pop_lo;
		logic pop_up;
		logic clear;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic lo_empty;
		logic up_empty;
		logic lo_fin;
		logic up_fin;
		logic cmp_lt;
		logic cmp_eq;
		logic mode;
		logic in_drop;
		logic hold_valid;
		logic out_free;
	} status_t;

	// Bytes after the first zero byte do not take part in ordering.
	function automatic id_t canon_id(input id_t v);
		id_t  r;
		logic stop;
		r    = '0;
		stop = 1'b0;
		for (int i = ID_BYTES - 1; i >= 0; i--) begin
			if (v[i*8 +: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				r[i*8 +: 8] = v[i*8 +: 8];
		end
		return r;
	endfunction

	function automatic code_t canon_code(input code_t v);
		code_t r;
		logic  stop;
		r    = '0;
		stop = 1'b0;
		for (int i = CODE_BYTES - 1; i >= 0; i--) begin
			if (v[i*8 +: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				r[i*8 +: 8] = v[i*8 +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/skm_datapath.sv]
`default_nettype none

module skm_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_write_en,
	input  wire logic            cfg_write_data,
	input  wire logic [1:0]      action,
	input  wire skm_pkg::id_t    key_id,
	input  wire skm_pkg::code_t  key_code,
	input  wire skm_pkg::cmd_t   cmd,
	output skm_pkg::status_t     status,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output skm_pkg::id_t         out_id,
	output skm_pkg::code_t       out_code,
	output logic                 stream_done,
	output logic                 dropped,
	output logic                 last_of_run
);
	import skm_pkg::*;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	action_t act;
	logic    act_key;
	logic    act_end;
	logic    act_sel;

	id_t   head_id   [2];
	code_t head_code [2];
	logic  full_w    [2];
	logic  empty_w   [2];
	logic  fin_w     [2];

	logic  mode_q;

	logic  hold_valid_q;
	id_t   hold_id_q;
	code_t hold_code_q;
	logic  hold_done_q;
	logic  hold_drop_q;

	logic  out_valid_q;
	id_t   out_id_q;
	code_t out_code_q;
	logic  out_done_q;
	logic  out_drop_q;
	logic  out_last_q;

	logic  in_drop;
	logic  load_hold;
	logic  move_out;
	logic  out_free;

	logic [ID_W+CODE_W-1:0] key_lo;
	logic [ID_W+CODE_W-1:0] key_up;

	assign act     = action_t'(action);
	assign act_key = (act == ACT_LOWER_KEY) || (act == ACT_UPPER_KEY);
	assign act_end = (act == ACT_LOWER_END) || (act == ACT_UPPER_END);
	assign act_sel = (act == ACT_UPPER_KEY) || (act == ACT_UPPER_END);

	for (genvar g = 0; g < 2; g++) begin : g_queue
		id_t               id_mem_q   [QUEUE_DEPTH];
		code_t             code_mem_q [QUEUE_DEPTH];
		logic [PTR_W-1:0]  rd_ptr_q;
		logic [PTR_W-1:0]  wr_ptr_q;
		logic [FILL_W-1:0] fill_q;
		logic              fin_q;
		logic              mine;
		logic              push;
		logic              pop;

		assign mine = (act_sel == 1'(g));
		assign push = cmd.take_in && act_key && mine && !fin_q && !full_w[g];
		assign pop  = (g == 0) ? cmd.pop_lo : cmd.pop_up;

		assign full_w[g]    = (fill_q == FILL_W'(QUEUE_DEPTH));
		assign empty_w[g]   = (fill_q == '0);
		assign fin_w[g]     = fin_q;
		assign head_id[g]   = id_mem_q[rd_ptr_q];
		assign head_code[g] = code_mem_q[rd_ptr_q];

		always_ff @(posedge clk) begin
			if (push) begin
				id_mem_q[wr_ptr_q]   <= key_id;
				code_mem_q[wr_ptr_q] <= key_code;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				fill_q   <= '0;
				fin_q    <= 1'b0;
			end else if (cmd.clear) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				fill_q   <= '0;
				fin_q    <= 1'b0;
			end else begin
				if (push)
					wr_ptr_q <= ptr_inc(wr_ptr_q);
				if (pop)
					rd_ptr_q <= ptr_inc(rd_ptr_q);
				unique case ({push, pop})
					2'b10:   fill_q <= fill_q + FILL_W'(1);
					2'b01:   fill_q <= fill_q - FILL_W'(1);
					default: fill_q <= fill_q;
				endcase
				if (cmd.take_in && act_end && mine)
					fin_q <= 1'b1;
			end
		end
	end

	assign in_drop = act_key && (act_sel ? (!fin_w[1] && full_w[1]) : (!fin_w[0] && full_w[0]));

	// ID then code, one wide unsigned compare
	assign key_lo = {canon_id(head_id[0]), canon_code(head_code[0])};
	assign key_up = {canon_id(head_id[1]), canon_code(head_code[1])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_write_en)
			mode_q <= cfg_write_data;
	end

	// hold stage keeps the newest result until we know whether it ends the run
	assign load_hold = (cmd.take_in && in_drop) || cmd.emit;
	assign move_out  = (cmd.emit || cmd.flush) && hold_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_valid_q <= 1'b0;
		else if (load_hold)
			hold_valid_q <= 1'b1;
		else if (cmd.flush)
			hold_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			hold_id_q   <= key_id;
			hold_code_q <= key_code;
			hold_done_q <= 1'b0;
			hold_drop_q <= 1'b1;
		end else if (cmd.emit) begin
			hold_drop_q <= 1'b0;
			unique case (cmd.src)
				SRC_LOWER: begin
					hold_id_q   <= head_id[0];
					hold_code_q <= head_code[0];
					hold_done_q <= 1'b0;
				end
				SRC_UPPER: begin
					hold_id_q   <= head_id[1];
					hold_code_q <= head_code[1];
					hold_done_q <= 1'b0;
				end
				default: begin
					hold_id_q   <= '0;
					hold_code_q <= '0;
					hold_done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (move_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			out_id_q   <= hold_id_q;
			out_code_q <= hold_code_q;
			out_done_q <= hold_done_q;
			out_drop_q <= hold_drop_q;
			out_last_q <= cmd.flush;
		end
	end

	assign status.lo_empty   = empty_w[0];
	assign status.up_empty   = empty_w[1];
	assign status.lo_fin     = fin_w[0];
	assign status.up_fin     = fin_w[1];
	assign status.cmp_lt     = key_lo < key_up;
	assign status.cmp_eq     = key_lo == key_up;
	assign status.mode       = mode_q;
	assign status.in_drop    = in_drop;
	assign status.hold_valid = hold_valid_q;
	assign status.out_free   = out_free;

	assign out_valid   = out_valid_q;
	assign out_id      = out_id_q;
	assign out_code    = out_code_q;
	assign stream_done = out_done_q;
	assign dropped     = out_drop_q;
	assign last_of_run = out_last_q;

endmodule

`default_nettype wire

[design/skm_ctrl.sv]
`default_nettype none

module skm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire skm_pkg::status_t  status,
	output skm_pkg::cmd_t          cmd
);
	import skm_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              blocked;
	logic              other_fin;
	src_t              solo_src;

	// a new result needs the hold stage to drain into the output register
	assign blocked   = status.hold_valid && !status.out_free;
	assign other_fin = status.lo_empty ? status.lo_fin : status.up_fin;
	assign solo_src  = status.lo_empty ? SRC_UPPER : SRC_LOWER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.take_in)
			cnt_q <= status.in_drop ? CNT_W'(1) : '0;
		else if (cmd.emit)
			cnt_q <= cnt_q + CNT_W'(1);
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_STEP;
				end
			end
			ST_STEP: begin
				priority if (cnt_q == CNT_W'(MAX_RESULTS)) begin
					state_d = ST_FLUSH;
				end else if (status.lo_empty && status.up_empty) begin
					if (status.lo_fin && status.up_fin) begin
						if (!blocked) begin
							cmd.emit  = 1'b1;
							cmd.src   = SRC_MARK;
							cmd.clear = 1'b1;
							state_d   = ST_FLUSH;
						end
					end else begin
						state_d = ST_FLUSH;
					end
				end else if (!status.lo_empty && !status.up_empty) begin
					if (!status.mode) begin
						if (!blocked) begin
							cmd.emit   = 1'b1;
							cmd.src    = (status.cmp_eq || status.cmp_lt) ? SRC_LOWER : SRC_UPPER;
							cmd.pop_lo = status.cmp_eq || status.cmp_lt;
							cmd.pop_up = !status.cmp_lt;
						end
					end else if (status.cmp_eq) begin
						// match hit: only the upper copy is consumed
						if (!blocked) begin
							cmd.emit   = 1'b1;
							cmd.src    = SRC_LOWER;
							cmd.pop_up = 1'b1;
						end
					end else if (status.cmp_lt) begin
						cmd.pop_lo = 1'b1;
					end else begin
						cmd.pop_up = 1'b1;
					end
				end else begin
					if (!other_fin) begin
						state_d = ST_FLUSH;
					end else if (!status.mode) begin
						if (!blocked) begin
							cmd.emit   = 1'b1;
							cmd.src    = solo_src;
							cmd.pop_lo = !status.lo_empty;
							cmd.pop_up = status.lo_empty;
						end
					end else begin
						cmd.pop_lo = !status.lo_empty;
						cmd.pop_up = status.lo_empty;
					end
				end
			end
			ST_FLUSH: begin
				if (!status.hold_valid) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[design/sorted_key_stream_merge_match.sv]
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------------
// input    | in_valid / in_stall  | action, key_id, key_code
// output   | out_valid / out_stall| out_id, out_code, stream_done, dropped, last_of_run
// config   | cfg_write_en         | cfg_write_data (combine_mode)
//
// An item passes through accept, the queue steps of the shared head
// comparator (emit or pop), a check that finds no step left, and the retire
// of the last result. An item that ends in the end marker skips the empty
// check, the marker counted as a step. An emitting step and the retire step
// wait while a result is held and the output register is full and stalled.
// Reset empties both queues at once; no clearing pass.
// The next item is accepted while the final result still sits in the output register.
`default_nettype none

module sorted_key_stream_merge_match (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_write_en,
	input  wire logic            cfg_write_data,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      action,
	input  wire skm_pkg::id_t    key_id,
	input  wire skm_pkg::code_t  key_code,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output skm_pkg::id_t         out_id,
	output skm_pkg::code_t       out_code,
	output logic                 stream_done,
	output logic                 dropped,
	output logic                 last_of_run
);
	import skm_pkg::*;

	cmd_t    cmd;
	status_t status;

	skm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	skm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.action         (action),
		.key_id         (key_id),
		.key_code       (key_code),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_id         (out_id),
		.out_code       (out_code),
		.stream_done    (stream_done),
		.dropped        (dropped),
		.last_of_run    (last_of_run)
	);

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && status.hold_valid |-> status.out_free)
		else $error("result issued while hold and output are both occupied");

	a_marker_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> status.lo_empty && status.up_empty && !status.lo_fin && !status.up_fin)
		else $error("queues not back to empty after end marker");

	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !status.hold_valid)
		else $error("new transaction possible while a result is still held");

endmodule

`default_nettype wire
